>>> rtl/pmq_pkg.sv
// Shared types, register codes and constants of the priority message queue.
`default_nettype none
package pmq_pkg;

	// One input item.
	typedef struct packed {
		logic        opcode;
		logic [3:0]  priority_req;
		logic [31:0] msg_word0;
		logic [31:0] msg_word1;
		logic [31:0] msg_word2;
		logic [31:0] msg_word3;
	} in_t;

	// One result item.
	typedef struct packed {
		logic        ok;
		logic [2:0]  out_priority;
		logic [31:0] out_word0;
		logic [31:0] out_word1;
		logic [31:0] out_word2;
		logic [31:0] out_word3;
	} out_t;

	// Stored entry of the message memory.
	typedef struct packed {
		logic [2:0]  prio;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} entry_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_METHOD         = 3'd0,
		CFG_QUEUE_COUNT    = 3'd1,
		CFG_PRIORITY_COUNT = 3'd2,
		CFG_QUEUE_MAP      = 3'd3,
		CFG_LIMITS_LOW     = 3'd4,
		CFG_LIMITS_HIGH    = 3'd5,
		CFG_SHARED_TOTAL   = 3'd6,
		CFG_WEIGHTS        = 3'd7
	} cfg_reg_t;

	localparam logic OP_PUT        = 1'b0;
	localparam logic OP_GET        = 1'b1;
	localparam logic METHOD_STRICT = 1'b0;
	localparam logic METHOD_WRR    = 1'b1;

	localparam logic        RST_METHOD      = 1'b0;
	localparam logic [3:0]  RST_QUEUE_COUNT = 4'd8;
	localparam logic [3:0]  RST_PRIO_COUNT  = 4'd8;
	localparam logic [23:0] RST_QUEUE_MAP   = 24'd16434824;
	localparam logic [39:0] RST_LIMITS      = 40'd68786651200;
	localparam logic [9:0]  RST_SHARED      = 10'd0;
	localparam logic [63:0] RST_WEIGHTS     = 64'd72340172838076673;

	// Credit reloaded for a queue: a zero weight acts as one.
	function automatic logic [7:0] weight_of(logic [63:0] w, logic [2:0] q);
		logic [7:0] v;
		v = w[8*q +: 8];
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic put_rd;
		logic strict_sel;
		logic wrr_start;
		logic seek;
		logic visit;
		logic wrr_fail;
		logic pop_rd;
		logic pop_wr;
		logic put_wr;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_get;
		logic is_wrr;
		logic put_ok;
		logic strict_hit;
		logic idx_nonempty;
		logic wrr_stop;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/pmq_ctrl.sv
// Controller state machine of the priority message queue.
`default_nettype none
module pmq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pmq_pkg::sts_t sts,
	output pmq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EVAL, S_PUT_WR, S_POP_RD, S_POP_WR, S_SEEK, S_VISIT, S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (!sts.is_get) begin
					if (sts.put_ok) begin
						cmd.put_rd = 1'b1;
						state_d    = S_PUT_WR;
					end else begin
						state_d = S_DONE;
					end
				end else if (sts.is_wrr) begin
					cmd.wrr_start = 1'b1;
					state_d       = S_SEEK;
				end else if (sts.strict_hit) begin
					cmd.strict_sel = 1'b1;
					state_d        = S_POP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUT_WR: begin
				cmd.put_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_SEEK: begin
				cmd.seek = 1'b1;
				state_d  = S_VISIT;
			end
			S_VISIT: begin
				cmd.visit = 1'b1;
				priority if (sts.idx_nonempty) begin
					state_d = S_POP_RD;
				end else if (sts.wrr_stop) begin
					cmd.wrr_fail = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_SEEK;
				end
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_POP_WR;
			end
			S_POP_WR: begin
				cmd.pop_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pmq_dpath.sv
// Datapath: registers, queue pointers, credits, free list and message memories.
`default_nettype none
module pmq_dpath #(
	parameter int POOL_DEPTH     = 512,
	parameter int MAX_QUEUES     = 8,
	parameter int MAX_PRIORITIES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmq_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  pmq_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pmq_pkg::out_t                     out_data,
	input  pmq_pkg::cmd_t                     cmd,
	output pmq_pkg::sts_t                     sts
);

	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int HW = $clog2(POOL_DEPTH + 1);
	localparam int SW = 13;

	// Configuration registers
	logic        method_q;
	logic [3:0]  qcount_q, pcount_q;
	logic [23:0] qmap_q;
	logic [39:0] lim_lo_q, lim_hi_q;
	logic [9:0]  shared_q;
	logic [63:0] weights_q;

	// Control state
	logic [IW-1:0] free_head_q;
	logic [HW-1:0] pool_used_q;
	logic [HW-1:0] hwm_q;
	logic [IW-1:0] head_q [MAX_QUEUES];
	logic [IW-1:0] tail_q [MAX_QUEUES];
	logic          ne_q   [MAX_QUEUES];
	logic [7:0]    cr_q   [MAX_QUEUES];
	logic [9:0]    occ_q  [MAX_PRIORITIES];
	logic [3:0]    rr_q;
	logic [3:0]    empties_q;
	logic [2:0]    idx_q;
	logic [2:0]    q_sel_q;
	logic [IW-1:0] e_q;
	logic          fresh_q;
	logic [IW-1:0] fresh_nxt_q;
	logic          out_valid_q;

	// Payload registers
	pmq_pkg::in_t   item_q;
	pmq_pkg::out_t  res_q, out_q;
	pmq_pkg::entry_t data_rd_q;
	logic [IW-1:0]  link_rd_q;

	// Memories
	pmq_pkg::entry_t data_mem [POOL_DEPTH];
	logic [IW-1:0]   link_mem [POOL_DEPTH];

	logic [3:0]  nq, np;
	logic [2:0]  map_a [8];
	logic [9:0]  lim_a [8];
	logic [7:0]  wgt_a [8];
	logic [SW-1:0] cap_sum, cap;
	logic [3:0]  put_p;
	logic [2:0]  put_q;
	logic [9:0]  put_lim;
	logic        put_ok;
	logic        strict_hit;
	logic [2:0]  strict_q;
	logic        any_ne;
	logic [3:0]  r0, cand;
	logic        seek_found;
	logic [2:0]  seek_idx;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] link_val;
	logic        lk_we;
	logic [IW-1:0] lk_addr, lk_wdata;

	// Effective counts
	always_comb begin
		if (qcount_q == 4'd0) begin
			nq = 4'd1;
		end else if (qcount_q > 4'(MAX_QUEUES)) begin
			nq = 4'(MAX_QUEUES);
		end else begin
			nq = qcount_q;
		end
		np = (pcount_q > 4'(MAX_PRIORITIES)) ? 4'(MAX_PRIORITIES) : pcount_q;
	end

	// Unpack map, limits and weights
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			map_a[i] = qmap_q[3*i +: 3];
			lim_a[i] = (i < 4) ? lim_lo_q[10*(i%4) +: 10] : lim_hi_q[10*(i%4) +: 10];
			wgt_a[i] = pmq_pkg::weight_of(weights_q, 3'(i));
		end
	end

	// Pool capacity
	always_comb begin
		cap_sum = '0;
		for (int p = 0; p < MAX_PRIORITIES; p++) begin
			if (4'(p) < np) begin
				cap_sum = cap_sum + SW'(lim_a[p]);
			end
		end
		cap = (shared_q != 10'd0) ? SW'(shared_q) : cap_sum;
		if (cap > SW'(POOL_DEPTH)) begin
			cap = SW'(POOL_DEPTH);
		end
	end

	// Admission check of a put
	always_comb begin
		put_p   = item_q.priority_req;
		put_q   = map_a[put_p[2:0]];
		put_lim = (shared_q != 10'd0) ? shared_q : lim_a[put_p[2:0]];
		put_ok  = (put_p < np) && ({1'b0, put_q} < nq) &&
			(occ_q[put_p[2:0]] < put_lim) && (SW'(pool_used_q) < cap);
	end

	// Strict scan: highest mapped non-empty priority wins
	always_comb begin
		strict_hit = 1'b0;
		strict_q   = '0;
		for (int p = 0; p < MAX_PRIORITIES; p++) begin
			if ((4'(p) < np) && ({1'b0, map_a[p]} < nq) && ne_q[map_a[p]]) begin
				strict_hit = 1'b1;
				strict_q   = map_a[p];
			end
		end
	end

	// Any non-empty queue in use
	always_comb begin
		any_ne = 1'b0;
		for (int i = 0; i < MAX_QUEUES; i++) begin
			if ((4'(i) < nq) && ne_q[i]) begin
				any_ne = 1'b1;
			end
		end
	end

	// Credit seek: walk down from below the pointer, wrapping within the queues in use
	always_comb begin
		r0         = (rr_q != 4'd0) ? rr_q - 4'd1 : nq - 4'd1;
		seek_found = 1'b0;
		seek_idx   = 3'(nq - 4'd1);
		cand       = '0;
		for (int k = 0; k < MAX_QUEUES; k++) begin
			cand = (r0 >= 4'(k)) ? r0 - 4'(k) : r0 + nq - 4'(k);
			if (!seek_found && (4'(k) < nq) && (cr_q[cand[2:0]] != 8'd0)) begin
				seek_found = 1'b1;
				seek_idx   = cand[2:0];
			end
		end
	end

	assign sts.is_get       = (item_q.opcode == pmq_pkg::OP_GET);
	assign sts.is_wrr       = (method_q == pmq_pkg::METHOD_WRR);
	assign sts.put_ok       = put_ok;
	assign sts.strict_hit   = strict_hit;
	assign sts.idx_nonempty = ne_q[idx_q];
	assign sts.wrr_stop     = !ne_q[idx_q] && (empties_q >= nq) && !any_ne;
	assign sts.out_free     = !out_valid_q || out_ready;

	assign rd_addr  = cmd.put_rd ? free_head_q : head_q[q_sel_q];
	// A link never written is taken as pointing to the next entry
	assign link_val = fresh_q ? fresh_nxt_q : link_rd_q;

	assign lk_we    = cmd.pop_wr || (cmd.put_wr && ne_q[q_sel_q]);
	assign lk_addr  = cmd.pop_wr ? e_q : tail_q[q_sel_q];
	assign lk_wdata = cmd.pop_wr ? free_head_q : e_q;

	// Memories: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.put_wr) begin
			data_mem[e_q] <= '{prio: item_q.priority_req[2:0], w0: item_q.msg_word0,
				w1: item_q.msg_word1, w2: item_q.msg_word2, w3: item_q.msg_word3};
		end
		if (lk_we) begin
			link_mem[lk_addr] <= lk_wdata;
		end
		if (cmd.put_rd || cmd.pop_rd) begin
			data_rd_q <= data_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.load) begin
			res_q <= '0;
		end else if (cmd.put_wr) begin
			res_q.ok <= 1'b1;
		end else if (cmd.pop_wr) begin
			res_q <= '{ok: 1'b1, out_priority: data_rd_q.prio, out_word0: data_rd_q.w0,
				out_word1: data_rd_q.w1, out_word2: data_rd_q.w2, out_word3: data_rd_q.w3};
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	// Configuration, queue state, credits and free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q    <= pmq_pkg::RST_METHOD;
			qcount_q    <= pmq_pkg::RST_QUEUE_COUNT;
			pcount_q    <= pmq_pkg::RST_PRIO_COUNT;
			qmap_q      <= pmq_pkg::RST_QUEUE_MAP;
			lim_lo_q    <= pmq_pkg::RST_LIMITS;
			lim_hi_q    <= pmq_pkg::RST_LIMITS;
			shared_q    <= pmq_pkg::RST_SHARED;
			weights_q   <= pmq_pkg::RST_WEIGHTS;
			free_head_q <= '0;
			pool_used_q <= '0;
			hwm_q       <= '0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				ne_q[i]   <= 1'b0;
				cr_q[i]   <= pmq_pkg::weight_of(pmq_pkg::RST_WEIGHTS, 3'(i));
			end
			for (int p = 0; p < MAX_PRIORITIES; p++) begin
				occ_q[p] <= '0;
			end
			rr_q        <= '0;
			empties_q   <= '0;
			idx_q       <= '0;
			q_sel_q     <= '0;
			e_q         <= '0;
			fresh_q     <= 1'b0;
			fresh_nxt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Register writes
			if (cfg_we) begin
				unique case (pmq_pkg::cfg_reg_t'(cfg_index))
					pmq_pkg::CFG_METHOD:         method_q  <= cfg_data[0];
					pmq_pkg::CFG_QUEUE_COUNT:    qcount_q  <= cfg_data[3:0];
					pmq_pkg::CFG_PRIORITY_COUNT: pcount_q  <= cfg_data[3:0];
					pmq_pkg::CFG_QUEUE_MAP:      qmap_q    <= cfg_data[23:0];
					pmq_pkg::CFG_LIMITS_LOW:     lim_lo_q  <= cfg_data[39:0];
					pmq_pkg::CFG_LIMITS_HIGH:    lim_hi_q  <= cfg_data[39:0];
					pmq_pkg::CFG_SHARED_TOTAL:   shared_q  <= cfg_data[9:0];
					pmq_pkg::CFG_WEIGHTS:        weights_q <= cfg_data;
					default:                     ;
				endcase
			end

			// Select the target queue
			if (cmd.put_rd) begin
				q_sel_q <= put_q;
			end
			if (cmd.strict_sel) begin
				q_sel_q <= strict_q;
			end

			// Issue a memory read and note whether its link is still fresh
			if (cmd.put_rd || cmd.pop_rd) begin
				e_q         <= rd_addr;
				fresh_q     <= (HW'(rd_addr) >= hwm_q);
				fresh_nxt_q <= (rd_addr == IW'(POOL_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
			end

			// Start a weighted round
			if (cmd.wrr_start) begin
				empties_q <= '0;
				if (rr_q > nq) begin
					rr_q <= nq;
				end
			end

			// Seek a queue with credit, reload all when none is left
			if (cmd.seek) begin
				idx_q <= seek_idx;
				if (!seek_found) begin
					for (int i = 0; i < MAX_QUEUES; i++) begin
						if (4'(i) < nq) begin
							cr_q[i] <= wgt_a[i];
						end
					end
				end
			end

			// Visit: spend a credit even on an empty queue; a failed walk parks the pointer
			if (cmd.visit) begin
				if (cr_q[idx_q] != 8'd0) begin
					cr_q[idx_q] <= cr_q[idx_q] - 8'd1;
				end
				rr_q <= cmd.wrr_fail ? nq : {1'b0, idx_q};
				if (ne_q[idx_q]) begin
					q_sel_q <= idx_q;
				end else if (empties_q >= nq) begin
					empties_q <= '0;
				end else begin
					empties_q <= empties_q + 4'd1;
				end
			end

			// Append the new entry
			if (cmd.put_wr) begin
				free_head_q         <= link_val;
				pool_used_q         <= pool_used_q + 1'b1;
				occ_q[put_p[2:0]]   <= occ_q[put_p[2:0]] + 10'd1;
				if (!ne_q[q_sel_q]) begin
					head_q[q_sel_q] <= e_q;
				end
				tail_q[q_sel_q] <= e_q;
				ne_q[q_sel_q]   <= 1'b1;
				if (HW'(e_q) >= hwm_q) begin
					hwm_q <= HW'(e_q) + 1'b1;
				end
			end

			// Pop the head entry and return it to the free list
			if (cmd.pop_wr) begin
				if (e_q == tail_q[q_sel_q]) begin
					ne_q[q_sel_q]   <= 1'b0;
					head_q[q_sel_q] <= '0;
					tail_q[q_sel_q] <= '0;
				end else begin
					head_q[q_sel_q] <= link_val;
				end
				free_head_q <= e_q;
				if (pool_used_q != '0) begin
					pool_used_q <= pool_used_q - 1'b1;
				end
				if ((4'(data_rd_q.prio) < 4'(MAX_PRIORITIES)) &&
					(occ_q[data_rd_q.prio] != 10'd0)) begin
					occ_q[data_rd_q.prio] <= occ_q[data_rd_q.prio] - 10'd1;
				end
			end

			// Output register
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

>>> rtl/priority_message_queue_wrr.sv
// Top level of the priority message queue with strict or weighted round robin dequeue.
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_data  (pmq_pkg::in_t)
//  out       out  out_valid / out_ready  out_data (pmq_pkg::out_t)
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// One item at a time: an accepted or rejected put, a strict get, or a weighted get that
// visits queues one after another and fails when it finds nothing.
// Reset clears all control state at once; no clearing pass over the memories.
// A stalled result waits in the output register; the next item is taken after it leaves
// the working stage.
`default_nettype none
module priority_message_queue_wrr #(
	parameter int POOL_DEPTH     = 512,
	parameter int MAX_QUEUES     = 8,
	parameter int MAX_PRIORITIES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pmq_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pmq_pkg::out_t                  out_data
);

	pmq_pkg::cmd_t cmd;
	pmq_pkg::sts_t sts;

	pmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmq_dpath #(
		.POOL_DEPTH     (POOL_DEPTH),
		.MAX_QUEUES     (MAX_QUEUES),
		.MAX_PRIORITIES (MAX_PRIORITIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

>>> rtl/pmq_checker.sv
// Port checker of the priority message queue and its bind.
`default_nettype none
module pmq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input pmq_pkg::out_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A failed result carries no message
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.out_priority == 3'd0 &&
		out_data.out_word0 == 32'd0 && out_data.out_word1 == 32'd0 &&
		out_data.out_word2 == 32'd0 && out_data.out_word3 == 32'd0)
		else $error("failed result not zero");

	// One item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind priority_message_queue_wrr pmq_checker u_pmq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
